[hw/rtl/terq_pkg.sv]
package terq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W       = 5;
    localparam int OUT_CNT_W   = 5;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int INST_W      = 32;
    localparam int KIND_W      = 8;
    localparam int SNAP_W      = 64;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUMP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY_INST = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd3;

    typedef struct packed {
        logic [INST_W-1:0] owner;
        logic [KIND_W-1:0] kind;
        logic [SNAP_W-1:0] payload;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;     // request accepted this cycle
        logic rd_issue;  // read the next queued entry
        logic step;      // consume the entry read last
        logic finish;    // load the summary, commit fill, and commit head after a pump
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new result
        logic pend;      // read data waiting to be consumed
        logic need_out;  // pending entry is to be delivered
        logic more;      // entries left to read
    } t_sts;

    // ring slot of a + b, both below twice the depth in sum
    function automatic logic [IDX_W-1:0] wrap_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/terq_ram.sv]
module terq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/terq_ctrl.sv]
module terq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [terq_pkg::MODE_W-1:0]  i_mode,
    input  terq_pkg::t_sts               i_sts,
    output logic                         o_in_ready,
    output terq_pkg::t_cmd               o_cmd
);
    import terq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;
    logic       step;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = o_in_ready && i_in_valid;
    // a delivered entry waits until the result register is free
    assign step       = (r_state == S_WALK) && i_sts.pend &&
                        (!i_sts.need_out || i_sts.out_free);

    always_comb begin
        o_cmd.start    = accept;
        o_cmd.step     = step;
        o_cmd.rd_issue = (r_state == S_WALK) && i_sts.more && (!i_sts.pend || step);
        o_cmd.finish   = (r_state == S_SUM) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_PUMP || i_mode == MODE_DISCARD)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!i_sts.more && !i_sts.pend) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/terq_dp.sv]
module terq_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [terq_pkg::LIM_W-1:0]      i_cfg_data,
    input  logic [terq_pkg::MODE_W-1:0]     i_mode,
    input  logic [terq_pkg::INST_W-1:0]     i_instance_id,
    input  logic [terq_pkg::KIND_W-1:0]     i_event_kind,
    input  logic [terq_pkg::SNAP_W-1:0]     i_snapshot,
    input  terq_pkg::t_cmd                  i_cmd,
    output terq_pkg::t_sts                  o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [terq_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_is_event,
    output logic [terq_pkg::INST_W-1:0]     o_out_instance,
    output logic [terq_pkg::KIND_W-1:0]     o_out_kind,
    output logic [terq_pkg::SNAP_W-1:0]     o_out_snapshot,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_consumed_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_stale_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_delivered_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_removed_count,
    output logic                            o_last
);
    import terq_pkg::*;

    localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    // queue state
    logic [IDX_W-1:0]  r_head,  n_head;
    logic [CNT_W-1:0]  r_fill,  n_fill;
    logic [LIM_W-1:0]  r_limit;
    // operation in progress
    logic [MODE_W-1:0] r_mode;
    logic [INST_W-1:0] r_inst;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_rd_cnt, n_rd_cnt;
    logic [CNT_W-1:0]  r_kept, n_kept;
    logic [CNT_W-1:0]  r_stale, n_stale;
    logic [CNT_W-1:0]  r_deliv, n_deliv;
    logic              r_pend, n_pend;
    // result register
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_status,    n_status;
    logic                 r_is_event,  n_is_event;
    logic [INST_W-1:0]    r_out_inst,  n_out_inst;
    logic [KIND_W-1:0]    r_out_kind,  n_out_kind;
    logic [SNAP_W-1:0]    r_out_snap,  n_out_snap;
    logic [OUT_CNT_W-1:0] r_consumed,  n_consumed;
    logic [OUT_CNT_W-1:0] r_stale_o,   n_stale_o;
    logic [OUT_CNT_W-1:0] r_deliv_o,   n_deliv_o;
    logic [OUT_CNT_W-1:0] r_removed,   n_removed;
    logic                 r_last,      n_last;

    logic              out_free;
    logic [CMP_W-1:0]  lim;
    logic [CMP_W-1:0]  fill_ext;
    logic [CNT_W-1:0]  pump_cnt;
    logic [CNT_W-1:0]  left;
    t_entry            rd_entry;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic              owner_hit;
    logic              deliver;
    logic              push_ok;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;

    assign out_free = !r_out_valid || i_out_ready;
    assign lim      = (r_limit == '0) ? CMP_W'(QUEUE_DEPTH) : CMP_W'(r_limit);
    assign fill_ext = CMP_W'(r_fill);
    assign pump_cnt = CNT_W'((lim < fill_ext) ? lim : fill_ext);
    assign left     = r_fill - r_total;

    assign rd_entry  = t_entry'(ram_rdata);
    assign owner_hit = (rd_entry.owner == r_inst);
    assign deliver   = (r_inst != '0) && owner_hit;
    assign push_ok   = (i_instance_id != '0) && (r_fill != CNT_W'(QUEUE_DEPTH));

    always_comb begin
        o_sts.out_free = out_free;
        o_sts.pend     = r_pend;
        o_sts.need_out = r_pend && (r_mode == MODE_PUMP) && deliver;
        o_sts.more     = (r_rd_cnt < r_total);
    end

    // survivors of a discard are packed behind the head in ring order, so
    // a write never lands on an entry still to be read
    always_comb begin
        ram_raddr = wrap_add(CNT_W'(r_head), r_rd_cnt);
        if (i_cmd.start) begin
            ram_we    = (i_mode == MODE_PUSH) && push_ok;
            ram_waddr = wrap_add(CNT_W'(r_head), r_fill);
            ram_wdata = '{owner: i_instance_id, kind: i_event_kind, payload: i_snapshot};
        end else begin
            ram_we    = i_cmd.step && (r_mode == MODE_DISCARD) && !owner_hit;
            ram_waddr = wrap_add(CNT_W'(r_head), r_kept);
            ram_wdata = rd_entry;
        end
    end

    terq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        n_total     = r_total;
        n_rd_cnt    = r_rd_cnt;
        n_kept      = r_kept;
        n_stale     = r_stale;
        n_deliv     = r_deliv;
        n_pend      = i_cmd.rd_issue ? 1'b1 : (i_cmd.step ? 1'b0 : r_pend);
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_is_event  = r_is_event;
        n_out_inst  = r_out_inst;
        n_out_kind  = r_out_kind;
        n_out_snap  = r_out_snap;
        n_consumed  = r_consumed;
        n_stale_o   = r_stale_o;
        n_deliv_o   = r_deliv_o;
        n_removed   = r_removed;
        n_last      = r_last;

        if (i_cmd.rd_issue) begin
            n_rd_cnt = r_rd_cnt + 1'b1;
        end

        if (i_cmd.start || i_cmd.finish || (i_cmd.step && o_sts.need_out)) begin
            n_out_valid = 1'b1;
            n_status    = ST_DONE;
            n_is_event  = 1'b0;
            n_out_inst  = '0;
            n_out_kind  = '0;
            n_out_snap  = '0;
            n_consumed  = '0;
            n_stale_o   = '0;
            n_deliv_o   = '0;
            n_removed   = '0;
            n_last      = 1'b1;
        end

        if (i_cmd.start) begin
            n_rd_cnt = '0;
            n_kept   = '0;
            n_stale  = '0;
            n_deliv  = '0;
            n_pend   = 1'b0;
            case (i_mode)
                MODE_PUSH: begin
                    if (i_instance_id == '0) begin
                        n_status = ST_EMPTY_INST;
                    end else if (!push_ok) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_ACCEPTED;
                        n_fill   = r_fill + 1'b1;
                    end
                end
                MODE_PUMP: begin
                    n_total     = pump_cnt;
                    n_out_valid = r_out_valid && !i_out_ready;
                end
                MODE_DISCARD: begin
                    n_total     = r_fill;
                    n_out_valid = r_out_valid && !i_out_ready;
                end
                default: begin
                    n_head = '0;
                    n_fill = '0;
                end
            endcase
        end

        if (i_cmd.step) begin
            if (r_mode == MODE_PUMP) begin
                if (deliver) begin
                    n_deliv    = r_deliv + 1'b1;
                    n_status   = ST_ACCEPTED;
                    n_is_event = 1'b1;
                    n_out_inst = rd_entry.owner;
                    n_out_kind = rd_entry.kind;
                    n_out_snap = rd_entry.payload;
                    n_last     = 1'b0;
                end else begin
                    n_stale = r_stale + 1'b1;
                end
            end else if (!owner_hit) begin
                n_kept = r_kept + 1'b1;
            end
        end

        if (i_cmd.finish) begin
            if (r_mode == MODE_PUMP) begin
                n_fill     = left;
                n_head     = (left == '0) ? '0 : wrap_add(CNT_W'(r_head), r_total);
                n_consumed = OUT_CNT_W'(r_total);
                n_stale_o  = OUT_CNT_W'(r_stale);
                n_deliv_o  = OUT_CNT_W'(r_deliv);
            end else begin
                n_fill    = r_kept;
                n_removed = OUT_CNT_W'(r_total - r_kept);
            end
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_limit     <= '0;
            r_total     <= '0;
            r_rd_cnt    <= '0;
            r_kept      <= '0;
            r_stale     <= '0;
            r_deliv     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_rd_cnt    <= n_rd_cnt;
            r_kept      <= n_kept;
            r_stale     <= n_stale;
            r_deliv     <= n_deliv;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_mode;
            r_inst <= i_instance_id;
        end
        r_status   <= n_status;
        r_is_event <= n_is_event;
        r_out_inst <= n_out_inst;
        r_out_kind <= n_out_kind;
        r_out_snap <= n_out_snap;
        r_consumed <= n_consumed;
        r_stale_o  <= n_stale_o;
        r_deliv_o  <= n_deliv_o;
        r_removed  <= n_removed;
        r_last     <= n_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_is_event        = r_is_event;
    assign o_out_instance    = r_out_inst;
    assign o_out_kind        = r_out_kind;
    assign o_out_snapshot    = r_out_snap;
    assign o_consumed_count  = r_consumed;
    assign o_stale_count     = r_stale_o;
    assign o_delivered_count = r_deliv_o;
    assign o_removed_count   = r_removed;
    assign o_last            = r_last;

endmodule

[hw/rtl/tagged_event_ring_queue_core.sv]
// channel   | handshake                    | payload
// request   | i_in_valid / o_in_ready      | i_mode, i_instance_id, i_event_kind, i_snapshot
// result    | o_out_valid / i_out_ready    | o_status ... o_last
// config    | i_cfg_we (no wait)           | i_cfg_data (pump limit)
//
// Push and clear complete on acceptance; the result sits in the output register next cycle.
// Pump and discard walk the ring through the single-port-read entry RAM, one entry
// a cycle unless the walk is held, and walk at most QUEUE_DEPTH entries.
// A delivered event holds the walk while the output register is still full.
// A new request is taken only between operations, with the output register free.
// Reset clears head, fill, pump limit and control; entry storage is not cleared.
module tagged_event_ring_queue_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [terq_pkg::LIM_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [terq_pkg::MODE_W-1:0]     i_mode,
    input  logic [terq_pkg::INST_W-1:0]     i_instance_id,
    input  logic [terq_pkg::KIND_W-1:0]     i_event_kind,
    input  logic [terq_pkg::SNAP_W-1:0]     i_snapshot,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [terq_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_is_event,
    output logic [terq_pkg::INST_W-1:0]     o_out_instance,
    output logic [terq_pkg::KIND_W-1:0]     o_out_kind,
    output logic [terq_pkg::SNAP_W-1:0]     o_out_snapshot,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_consumed_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_stale_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_delivered_count,
    output logic [terq_pkg::OUT_CNT_W-1:0]  o_removed_count,
    output logic                            o_last
);
    import terq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    terq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    terq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_instance_id     (i_instance_id),
        .i_event_kind      (i_event_kind),
        .i_snapshot        (i_snapshot),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_is_event        (o_is_event),
        .o_out_instance    (o_out_instance),
        .o_out_kind        (o_out_kind),
        .o_out_snapshot    (o_out_snapshot),
        .o_consumed_count  (o_consumed_count),
        .o_stale_count     (o_stale_count),
        .o_delivered_count (o_delivered_count),
        .o_removed_count   (o_removed_count),
        .o_last            (o_last)
    );

`ifndef SYNTH
    a_ready_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("request taken while a result is still held");

    a_short_op_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_PUSH || i_mode == MODE_CLEAR))
        |=> (o_out_valid && o_last))
        else $error("push or clear gave no final result");

    a_event_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_event) |-> !o_last)
        else $error("delivered event marked as final result");

    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.pend |-> !o_in_ready)
        else $error("request taken during a ring walk");
`endif

endmodule
